FILE: rtl/sorted_priority_queue_core_macros.svh
// assertion macros for the sorted priority queue core
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define SPQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted priority queue check failed");
// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority queue check failed");
`else
`define SPQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/spq_pkg.sv
`default_nettype none
package spq_pkg;

   // defaults for the top level parameters
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int FIELD_WIDTH_DEF = 16;

   // fixed port field widths
   localparam int DATA_W = 16;
   localparam int OCC_W  = 5;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type              operation;
      logic [DATA_W-1:0]   new_score;
      logic [DATA_W-1:0]   new_arrival;
      logic [DATA_W-1:0]   new_id;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [DATA_W-1:0]   out_score;
      logic [DATA_W-1:0]   out_arrival;
      logic [DATA_W-1:0]   out_id;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic enq;
      logic deq;
   } cmd_type;

endpackage
`default_nettype wire

FILE: rtl/spq_cell.sv
`default_nettype none
module spq_cell #(
   parameter int FIELD_WIDTH = spq_pkg::FIELD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire spq_pkg::cmd_type       cmd,
   input  wire logic                   slot_used,
   input  wire logic [FIELD_WIDTH-1:0] new_score,
   input  wire logic [FIELD_WIDTH-1:0] new_arrival,
   input  wire logic [FIELD_WIDTH-1:0] new_id,
   input  wire logic                   left_shift,
   input  wire logic [FIELD_WIDTH-1:0] left_score,
   input  wire logic [FIELD_WIDTH-1:0] left_arrival,
   input  wire logic [FIELD_WIDTH-1:0] left_id,
   input  wire logic [FIELD_WIDTH-1:0] right_score,
   input  wire logic [FIELD_WIDTH-1:0] right_arrival,
   input  wire logic [FIELD_WIDTH-1:0] right_id,
   output logic                        shift_out,
   output logic [FIELD_WIDTH-1:0]      score,
   output logic [FIELD_WIDTH-1:0]      arrival,
   output logic [FIELD_WIDTH-1:0]      id
);

   logic [FIELD_WIDTH-1:0] score_ff, score_in;
   logic [FIELD_WIDTH-1:0] arrival_ff, arrival_in;
   logic [FIELD_WIDTH-1:0] id_ff, id_in;
   logic                   new_first;

   // new entry is served strictly before the one held here
   assign new_first = (new_score > score_ff) ||
                      ((new_score == score_ff) && (new_arrival < arrival_ff));
   assign shift_out = slot_used && new_first;

   // next entry: pull from the right on dequeue, open a gap on enqueue
   always_comb begin
      score_in   = score_ff;
      arrival_in = arrival_ff;
      id_in      = id_ff;
      if (cmd.deq) begin
         score_in   = right_score;
         arrival_in = right_arrival;
         id_in      = right_id;
      end else if (cmd.enq && (!slot_used || new_first)) begin
         if (left_shift) begin
            score_in   = left_score;
            arrival_in = left_arrival;
            id_in      = left_id;
         end else begin
            score_in   = new_score;
            arrival_in = new_arrival;
            id_in      = new_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      score_ff   <= score_in;
      arrival_ff <= arrival_in;
      id_ff      <= id_in;
   end

   assign score   = score_ff;
   assign arrival = arrival_ff;
   assign id      = id_ff;

endmodule
`default_nettype wire

FILE: rtl/sorted_priority_queue_core.sv
`default_nettype none
// sorted priority queue: a chain of cells kept in service order, best entry in cell 0
// the result strobe rises in the cycle after the transaction is taken
// throughput: one enqueue or dequeue per cycle, set by the single-step cell update
// busy is never raised; the receiver cannot stall and takes every result
// reset clears the entry count and result strobe; cell contents are left as they are
module sorted_priority_queue_core #(
   parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
   parameter int FIELD_WIDTH = spq_pkg::FIELD_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   output spq_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                   accept;
   logic                   is_deq;
   logic                   full;
   logic                   empty;
   spq_pkg::cmd_type       cmd;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   rsp_valid_ff;
   spq_pkg::rsp_type       rsp_ff, rsp_in;
   logic [FIELD_WIDTH-1:0] new_score, new_arrival, new_id;
   logic [FIELD_WIDTH-1:0] score_w   [QUEUE_DEPTH];
   logic [FIELD_WIDTH-1:0] arrival_w [QUEUE_DEPTH];
   logic [FIELD_WIDTH-1:0] id_w      [QUEUE_DEPTH];
   logic                   shift_w   [QUEUE_DEPTH];
   logic                   head_in_order;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign is_deq = (req_data.operation == spq_pkg::OP_DEQUEUE);
   assign full   = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty  = (count_ff == '0);

   // only legal transactions move the chain
   assign cmd.enq = accept && !is_deq && !full;
   assign cmd.deq = accept && is_deq && !empty;

   // stored fields keep their low bits
   assign new_score   = FIELD_WIDTH'(req_data.new_score);
   assign new_arrival = FIELD_WIDTH'(req_data.new_arrival);
   assign new_id      = FIELD_WIDTH'(req_data.new_id);

   // chain of cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                   l_shift;
      logic [FIELD_WIDTH-1:0] l_score, l_arrival, l_id;
      logic [FIELD_WIDTH-1:0] r_score, r_arrival, r_id;

      if (i == 0) begin : g_head
         assign l_shift   = 1'b0;
         assign l_score   = new_score;
         assign l_arrival = new_arrival;
         assign l_id      = new_id;
      end else begin : g_left
         assign l_shift   = shift_w[i-1];
         assign l_score   = score_w[i-1];
         assign l_arrival = arrival_w[i-1];
         assign l_id      = id_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign r_score   = score_w[i];
         assign r_arrival = arrival_w[i];
         assign r_id      = id_w[i];
      end else begin : g_right
         assign r_score   = score_w[i+1];
         assign r_arrival = arrival_w[i+1];
         assign r_id      = id_w[i+1];
      end

      spq_cell #(
         .FIELD_WIDTH (FIELD_WIDTH)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .slot_used     (CNT_W'(i) < count_ff),
         .new_score     (new_score),
         .new_arrival   (new_arrival),
         .new_id        (new_id),
         .left_shift    (l_shift),
         .left_score    (l_score),
         .left_arrival  (l_arrival),
         .left_id       (l_id),
         .right_score   (r_score),
         .right_arrival (r_arrival),
         .right_id      (r_id),
         .shift_out     (shift_w[i]),
         .score         (score_w[i]),
         .arrival       (arrival_w[i]),
         .id            (id_w[i])
      );
   end

   // entry count and result for the transaction
   always_comb begin
      count_in           = count_ff;
      rsp_in             = rsp_ff;
      if (accept) begin
         rsp_in.status      = spq_pkg::ST_DONE;
         rsp_in.out_score   = '0;
         rsp_in.out_arrival = '0;
         rsp_in.out_id      = '0;
         if (is_deq) begin
            if (empty) begin
               rsp_in.status = spq_pkg::ST_EMPTY;
            end else begin
               rsp_in.out_score   = spq_pkg::DATA_W'(score_w[0]);
               rsp_in.out_arrival = spq_pkg::DATA_W'(arrival_w[0]);
               rsp_in.out_id      = spq_pkg::DATA_W'(id_w[0]);
               count_in           = count_ff - CNT_W'(1);
            end
         end else begin
            if (full) begin
               rsp_in.status = spq_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         rsp_in.occupancy = spq_pkg::OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // first two cells in service order
   assign head_in_order = (score_w[0] > score_w[1]) ||
                          ((score_w[0] == score_w[1]) && (arrival_w[0] <= arrival_w[1]));

   // checks
   `include "sorted_priority_queue_core_macros.svh"

   `SPQ_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `SPQ_ASSERT_NEXT(a_one_result, clock, reset, accept, rsp_valid)
   `SPQ_ASSERT_NEXT(a_deq_count, clock, reset, cmd.deq, count_ff == $past(count_ff) - CNT_W'(1))
   `SPQ_ASSERT_IMPL(a_head_order, clock, reset, count_ff >= CNT_W'(2), head_in_order)

endmodule
`default_nettype wire

FILE: bench/spq_order_checker.sv
`default_nettype none
module spq_order_checker
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_W-1:0] score;
      logic [DATA_W-1:0] arrival;
      logic [DATA_W-1:0] id;
   } queue_entry_type;

   // shadow copy of the queue, index 0 holds the best entry
   queue_entry_type held_entries [QUEUE_DEPTH];
   int              held_count;
   rsp_type         predicted_rsp [$];

   // true when the new entry is served ahead of the stored one
   function automatic bit served_ahead(input req_type cmd, input queue_entry_type stored);
      if (cmd.new_score != stored.score)
         return cmd.new_score > stored.score;
      return cmd.new_arrival < stored.arrival;
   endfunction

   // apply one transaction to the shadow queue and return its response
   function automatic rsp_type queue_step_rsp(input req_type cmd);
      rsp_type rsp;
      int      slot;
      rsp = '0;
      rsp.status = ST_DONE;
      if (cmd.operation == OP_DEQUEUE) begin
         if (held_count == 0) begin
            rsp.status = ST_EMPTY;
         end else begin
            rsp.out_score   = held_entries[0].score;
            rsp.out_arrival = held_entries[0].arrival;
            rsp.out_id      = held_entries[0].id;
            for (int i = 1; i < held_count; i++)
               held_entries[i-1] = held_entries[i];
            held_count--;
         end
      end else begin
         if (held_count >= QUEUE_DEPTH) begin
            rsp.status = ST_FULL;
         end else begin
            // ripple lower-priority entries down, ties keep enqueue order
            slot = held_count;
            while (slot > 0 && served_ahead(cmd, held_entries[slot-1])) begin
               held_entries[slot] = held_entries[slot-1];
               slot--;
            end
            held_entries[slot] = '{cmd.new_score, cmd.new_arrival, cmd.new_id};
            held_count++;
         end
      end
      rsp.occupancy = held_count[OCC_W-1:0];
      return rsp;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic compare_rsp(input rsp_type got, input rsp_type want);
      if (got.status !== want.status)
         report_mismatch("status", got.status, want.status);
      if (got.out_score !== want.out_score)
         report_mismatch("out_score", got.out_score, want.out_score);
      if (got.out_arrival !== want.out_arrival)
         report_mismatch("out_arrival", got.out_arrival, want.out_arrival);
      if (got.out_id !== want.out_id)
         report_mismatch("out_id", got.out_id, want.out_id);
      if (got.occupancy !== want.occupancy)
         report_mismatch("occupancy", got.occupancy, want.occupancy);
   endtask

   // predict on every accepted transaction, compare every strobed response
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         predicted_rsp.delete();
      end else begin
         if (start && !busy)
            predicted_rsp.push_back(queue_step_rsp(req_data));
         if (rsp_valid) begin
            if (predicted_rsp.size() == 0)
               report_mismatch("unexpected response", rsp_data, 0);
            else
               compare_rsp(rsp_data, predicted_rsp.pop_front());
         end
      end
      pending = predicted_rsp.size();
   end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none
module testbench;
   import spq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = QUEUE_DEPTH_DEF;
   localparam int RANDOM_CMDS = 900;
   localparam int CYCLE_LIMIT = 200000;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      burst_left = 0;
   int      cycle_count = 0;

   sorted_priority_queue_core #(
      .QUEUE_DEPTH (DEPTH),
      .FIELD_WIDTH (FIELD_WIDTH_DEF)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   spq_order_checker #(
      .QUEUE_DEPTH (DEPTH)
   ) order_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL sorted_priority_queue_core");
         $finish;
      end
   end

   // issue one transaction, then maybe end the burst with an idle gap
   task automatic send_cmd(input op_type op, input logic [DATA_W-1:0] score,
                           input logic [DATA_W-1:0] arrival, input logic [DATA_W-1:0] id);
      int gap;
      start    <= 1'b1;
      req_data <= '{op, score, arrival, id};
      do @(posedge clock); while (busy);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         // now and then a long stretch with no idling
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(0, 15);
      end
   endtask

   initial begin
      int            enq_pct;
      logic [DATA_W-1:0] score;
      logic [DATA_W-1:0] arrival;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: dequeue on empty, field extremes, ties, full queue
      send_cmd(OP_DEQUEUE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_cmd(OP_ENQUEUE, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_cmd(OP_ENQUEUE, 16'h0000, 16'hFFFF, 16'h0000);
      send_cmd(OP_ENQUEUE, 16'h0000, 16'h0000, 16'h0001);
      send_cmd(OP_ENQUEUE, 16'h0000, 16'hFFFF, 16'h0002);
      send_cmd(OP_ENQUEUE, 16'h8000, 16'h1234, 16'hAAAA);
      send_cmd(OP_ENQUEUE, 16'h8000, 16'h1234, 16'h5555);
      send_cmd(OP_ENQUEUE, 16'h8000, 16'h1233, 16'h0F0F);
      for (int k = 0; k < DEPTH - 7; k++)
         send_cmd(OP_ENQUEUE, DATA_W'(16'h1000 * k), 16'(k * 3), DATA_W'(16'h7000 + k));
      send_cmd(OP_ENQUEUE, 16'hFFFF, 16'h0000, 16'hBEEF);
      repeat (5) send_cmd(OP_DEQUEUE, 16'h0000, 16'h0000, 16'h0000);

      // random: enqueue bias swings so the queue sweeps between empty and full
      enq_pct = 50;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (n % 48 == 0) begin
            case ($urandom_range(0, 2))
               0: enq_pct = 85;
               1: enq_pct = 50;
               default: enq_pct = 15;
            endcase
         end
         // narrow ranges force score and arrival ties
         if ($urandom_range(0, 1) == 0) begin
            score   = DATA_W'($urandom_range(0, 3));
            arrival = DATA_W'($urandom_range(0, 3));
         end else begin
            score   = DATA_W'($urandom);
            arrival = DATA_W'($urandom);
         end
         if ($urandom_range(1, 100) <= enq_pct)
            send_cmd(OP_ENQUEUE, score, arrival, DATA_W'($urandom));
         else
            send_cmd(OP_DEQUEUE, score, arrival, DATA_W'($urandom));
      end
      start <= 1'b0;

      // drain outstanding responses, then allow for the pipeline
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fail_count == 0)
         $display("PASS sorted_priority_queue_core");
      else
         $display("FAIL sorted_priority_queue_core");
      $finish;
   end

endmodule
`default_nettype wire
